// ===== rtl/core/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants for the smoothed stereo biquad
// Holds the coefficient count and width, register indexes, the controller
// state type, the tap codes and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int NUM_COEF  = 5;
    localparam int COEF_W    = 32;
    localparam int RATE_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FF0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FF2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 3'd5;

    // filter taps, issued one per cycle to the shared multipliers
    typedef enum logic [2:0] {
        TAP_FF0 = 3'd0,
        TAP_FF1 = 3'd1,
        TAP_FF2 = 3'd2,
        TAP_FB1 = 3'd3,
        TAP_FB2 = 3'd4
    } t_tap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SUPD,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;        // capture input sample pair
        logic smooth_mul;  // form rate * (target - coef) products
        logic smooth_upd;  // apply rounded step, preset accumulators
        logic mul_en;      // issue one tap product per channel
        t_tap tap;         // which tap to issue
        logic finish;      // round, saturate, shift history, load output
    } t_dp_cmd;

endpackage

// ===== rtl/core/sbq_dp.sv =====
// ----------------------------------------------------------------------------
// sbq_dp: datapath of the smoothed stereo biquad
// Target/rate registers, working coefficients with parallel smoothing
// multipliers, one shared MAC per channel, histories and output registers.
// ----------------------------------------------------------------------------
module sbq_dp import sbq_pkg::*; #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_x_l,
    input  logic signed [SAMPLE_BITS-1:0] i_x_r,
    input  t_dp_cmd                       i_cmd,
    output logic signed [SAMPLE_BITS-1:0] o_y_l,
    output logic signed [SAMPLE_BITS-1:0] o_y_r,
    output logic                          o_clip
);

    localparam int DIFF_W = COEF_W + 1;
    localparam int SP_W   = RATE_W + 1 + DIFF_W;
    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int RES_W  = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  ACC_RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SP_W-1:0]   SP_RND   = SP_W'(32768);

    logic signed [COEF_W-1:0]      r_tgt  [NUM_COEF];
    logic        [RATE_W-1:0]      r_rate;
    logic signed [COEF_W-1:0]      r_coef [NUM_COEF];
    logic signed [SP_W-1:0]        r_sp   [NUM_COEF];
    logic signed [SAMPLE_BITS-1:0] r_x_l, r_x_r;
    logic signed [SAMPLE_BITS-1:0] r_xh_l [2];
    logic signed [SAMPLE_BITS-1:0] r_yh_l [2];
    logic signed [SAMPLE_BITS-1:0] r_xh_r [2];
    logic signed [SAMPLE_BITS-1:0] r_yh_r [2];
    logic signed [PROD_W-1:0]      r_prod_l, r_prod_r;
    logic                          r_prod_vld;
    logic                          r_prod_sub;
    logic signed [ACC_W-1:0]       r_acc_l, r_acc_r;
    logic signed [SAMPLE_BITS-1:0] r_y_l, r_y_r;
    logic                          r_clip;

    logic signed [SP_W-1:0]        n_sp   [NUM_COEF];
    logic signed [COEF_W-1:0]      n_coef [NUM_COEF];
    logic signed [COEF_W-1:0]      op_c;
    logic signed [SAMPLE_BITS-1:0] op_l, op_r;
    logic                          op_sub;
    logic signed [RES_W-1:0]       res_l, res_r;
    logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
    logic                          clip_l, clip_r;

    // smoothing: step = floor((rate * (t - c) + 2^15) / 2^16)
    always_comb begin
        for (int i = 0; i < NUM_COEF; i++) begin
            logic signed [DIFF_W-1:0] diff;
            logic signed [SP_W-1:0]   rnd;
            diff      = DIFF_W'(r_tgt[i]) - DIFF_W'(r_coef[i]);
            n_sp[i]   = $signed({1'b0, r_rate}) * diff;
            rnd       = r_sp[i] + SP_RND;
            n_coef[i] = r_coef[i] + rnd[16 +: COEF_W];
        end
    end

    // tap operand select
    always_comb begin
        op_c   = r_coef[0];
        op_l   = r_x_l;
        op_r   = r_x_r;
        op_sub = 1'b0;
        case (i_cmd.tap)
            TAP_FF0: begin
                op_c = r_coef[0]; op_l = r_x_l;     op_r = r_x_r;
            end
            TAP_FF1: begin
                op_c = r_coef[1]; op_l = r_xh_l[0]; op_r = r_xh_r[0];
            end
            TAP_FF2: begin
                op_c = r_coef[2]; op_l = r_xh_l[1]; op_r = r_xh_r[1];
            end
            TAP_FB1: begin
                op_c = r_coef[3]; op_l = r_yh_l[0]; op_r = r_yh_r[0]; op_sub = 1'b1;
            end
            TAP_FB2: begin
                op_c = r_coef[4]; op_l = r_yh_l[1]; op_r = r_yh_r[1]; op_sub = 1'b1;
            end
            default: begin
                op_c = r_coef[0];
            end
        endcase
    end

    // rounding was preset into the accumulator; drop the fraction bits
    assign res_l = r_acc_l[ACC_W-1:COEF_FRAC_BITS];
    assign res_r = r_acc_r[ACC_W-1:COEF_FRAC_BITS];

    function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] lim_hi;
        logic signed [RES_W-1:0] lim_lo;
        lim_hi = $signed({{(RES_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
        lim_lo = $signed({{(RES_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});
        if (v > lim_hi) begin
            saturate = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (v < lim_lo) begin
            saturate = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            saturate = {1'b0, v[SAMPLE_BITS-1:0]};
        end
    endfunction

    assign {clip_l, sat_l} = saturate(res_l);
    assign {clip_r, sat_r} = saturate(res_r);

    // configuration and coefficient state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_tgt[i]  <= (i == 0) ? COEF_ONE : '0;
                r_coef[i] <= (i == 0) ? COEF_ONE : '0;
            end
            r_rate <= RATE_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FF0:  r_tgt[0] <= i_cfg_data;
                    CFG_FF1:  r_tgt[1] <= i_cfg_data;
                    CFG_FF2:  r_tgt[2] <= i_cfg_data;
                    CFG_FB1:  r_tgt[3] <= i_cfg_data;
                    CFG_FB2:  r_tgt[4] <= i_cfg_data;
                    CFG_RATE: r_rate   <= i_cfg_data[RATE_W-1:0];
                    default:  ;
                endcase
            end
            if (i_cmd.smooth_upd) begin
                for (int i = 0; i < NUM_COEF; i++) begin
                    r_coef[i] <= n_coef[i];
                end
            end
        end
    end

    // histories and product valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_xh_l[i] <= '0;
                r_yh_l[i] <= '0;
                r_xh_r[i] <= '0;
                r_yh_r[i] <= '0;
            end
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.finish) begin
                r_xh_l[1] <= r_xh_l[0];
                r_xh_l[0] <= r_x_l;
                r_yh_l[1] <= r_yh_l[0];
                r_yh_l[0] <= sat_l;
                r_xh_r[1] <= r_xh_r[0];
                r_xh_r[0] <= r_x_r;
                r_yh_r[1] <= r_yh_r[0];
                r_yh_r[0] <= sat_r;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_l <= i_x_l;
            r_x_r <= i_x_r;
        end
        if (i_cmd.smooth_mul) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_sp[i] <= n_sp[i];
            end
        end
        if (i_cmd.mul_en) begin
            r_prod_l   <= op_c * op_l;
            r_prod_r   <= op_c * op_r;
            r_prod_sub <= op_sub;
        end
        if (i_cmd.smooth_upd) begin
            r_acc_l <= ACC_RND;
            r_acc_r <= ACC_RND;
        end else if (r_prod_vld) begin
            if (r_prod_sub) begin
                r_acc_l <= r_acc_l - ACC_W'(r_prod_l);
                r_acc_r <= r_acc_r - ACC_W'(r_prod_r);
            end else begin
                r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
                r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
            end
        end
        if (i_cmd.finish) begin
            r_y_l  <= sat_l;
            r_y_r  <= sat_r;
            r_clip <= clip_l | clip_r;
        end
    end

    assign o_y_l  = r_y_l;
    assign o_y_r  = r_y_r;
    assign o_clip = r_clip;

endmodule

// ===== rtl/core/sbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbq_ctrl: sequencer of the smoothed stereo biquad
// Walks smoothing, five tap products and the finish step; owns both
// handshakes and the output valid register.
// ----------------------------------------------------------------------------
module sbq_ctrl import sbq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_tap, n_tap;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tap     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tap     <= n_tap;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        o_cmd.tap = t_tap'(r_tap);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SMUL;
                end
            end
            ST_SMUL: begin
                o_cmd.smooth_mul = 1'b1;
                n_state          = ST_SUPD;
            end
            ST_SUPD: begin
                o_cmd.smooth_upd = 1'b1;
                n_tap            = 3'(TAP_FF0);
                n_state          = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mul_en = 1'b1;
                n_tap        = r_tap + 3'd1;
                if (r_tap == 3'(TAP_FB2)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold while an earlier result is still unclaimed
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ===== rtl/core/smoothed_biquad_stereo_core.sv =====
// ----------------------------------------------------------------------------
// smoothed_biquad_stereo_core: stereo DF1 biquad with coefficient smoothing
// Five working coefficients glide toward their targets once per sample pair,
// then both channels are filtered with the shared set and saturated.
//
// Usage:
//   s_axis beat: one stereo sample pair. m_axis beat: one filtered pair, with
//   the clip flag in tuser. Config port: write target_ff0..fb2 (index 0..4,
//   signed Q3.28) and smooth_rate (index 5, Q0.16) while the core is idle;
//   other indexes are dropped.
//   Steps in order: smoothing multiply, coefficient update, five tap products
//   on the per-channel shared multiplier, accumulate drain and round/saturate.
//   s_axis_tready is high only while no pair is in work. A finished result
//   sits in the output register; the next pair is taken meanwhile and only
//   its final step waits for m_axis_tready.
//   Reset (synchronous, active low): coefficients and target ff0 = 1.0, the
//   rest 0, rate 655, histories cleared, no result pending.
// ----------------------------------------------------------------------------
module smoothed_biquad_stereo_core import sbq_pkg::*; #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [SB-1:0] sample_left, [2*SB-1:SB] sample_right, zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [SB-1:0] filtered_left, [2*SB-1:SB] filtered_right, zero padded to bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // [0] clipped
    output logic                        m_axis_tuser
);

    localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

    t_dp_cmd                       cmd;
    logic signed [SAMPLE_BITS-1:0] y_l, y_r;
    logic                          clip;
    logic [DATA_W-1:0]             out_data;

    sbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    sbq_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_x_l       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_x_r       (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_cmd       (cmd),
        .o_y_l       (y_l),
        .o_y_r       (y_r),
        .o_clip      (clip)
    );

    // pad bits stay zero
    always_comb begin
        out_data = '0;
        out_data[2*SAMPLE_BITS-1:0] = {y_r, y_l};
    end

    assign m_axis_tdata = out_data;
    assign m_axis_tuser = clip;

    // one pair in work at a time: taking a beat closes the input
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input stayed open after a beat was taken");

    // a new result only comes out of a busy core
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

    // datapath commands never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.smooth_mul, cmd.smooth_upd, cmd.mul_en, cmd.finish}))
        else $error("overlapping datapath commands");

    // finishing never overwrites an unclaimed result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

endmodule
